[design/kmdis_pkg.sv]
// Package for the key matrix debouncer with idle sleep.
// Holds matrix geometry, field widths, register indexes and command codes.
// No dependencies.
`default_nettype none
package kmdis_pkg;
	localparam int ROWS = 5;
	localparam int COLS = 16;
	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

	localparam int ROW_IDX_W = 3;
	localparam int COL_BITS_W = 16;
	localparam int DELAY_W = 8;
	localparam int IDLE_W = 26;
	localparam int CFG_DATA_W = 26;
	localparam int CFG_IDX_W = 1;

	localparam logic [IDLE_W-1:0] IDLE_MAX = {IDLE_W{1'b1}};
	localparam logic [DELAY_W-1:0] DELAY_RESET = 8'd5;
	localparam logic [IDLE_W-1:0] PSAVE_RESET = 26'd600000;

	// Column mask limited to the number of physical columns
	localparam logic [COL_BITS_W-1:0] COL_MASK =
		COL_BITS_W'((33'd1 << COLS) - 33'd1);

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_DELAY = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_POWER_SAVE = 1'b1;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	typedef logic [COL_BITS_W-1:0] row_bits_t;
endpackage
`default_nettype wire

[design/kmdis_if.sv]
// Channel interfaces for the key matrix debouncer: sample/tick input and result output.
// Depends on kmdis_pkg for field widths.
`default_nettype none
interface kmdis_in_if;
	import kmdis_pkg::*;
	logic valid;
	logic ready;
	logic command;
	logic [ROW_IDX_W-1:0] row_index;
	logic [COL_BITS_W-1:0] column_bits;
	logic scan_end;

	modport source(output valid, command, row_index, column_bits, scan_end, input ready);
	modport sink(input valid, command, row_index, column_bits, scan_end, output ready);
endinterface

interface kmdis_out_if;
	import kmdis_pkg::*;
	logic valid;
	logic ready;
	logic [COL_BITS_W-1:0] stable_row;
	logic row_changed;
	logic committed;
	logic entered_sleep;
	logic woke_up;
	logic asleep;

	modport source(output valid, stable_row, row_changed, committed, entered_sleep, woke_up,
		asleep, input ready);
	modport sink(input valid, stable_row, row_changed, committed, entered_sleep, woke_up,
		asleep, output ready);
endinterface
`default_nettype wire

[design/key_matrix_debounce_idle_sleep.sv]
// Key matrix debouncer with idle sleep: pending/stable row stores, idle counter, sleep flag.
// Uses kmdis_pkg and the channel interfaces in kmdis_if.sv.
// Each transaction (row sample or millisecond tick) is captured in an input register and
// resolved combinationally against the row stores and idle counter into a result register,
// so one transaction is accepted every cycle while the output side is not stalled, and
// each yields exactly one result through the input register and then the result register.
// The result register and input register let a new transaction in while a finished
// result waits. No clearing pass is needed after reset; the row stores reset directly.
`default_nettype none
module key_matrix_debounce_idle_sleep (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [kmdis_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [kmdis_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	kmdis_in_if.sink                               samples,
	kmdis_out_if.source                            results
);
	import kmdis_pkg::*;

	// configuration
	logic [DELAY_W-1:0] delay_q;
	logic [IDLE_W-1:0]  psave_q;

	// input register
	logic                 s1_valid;
	logic                 cmd_s1;
	logic [ROW_IDX_W-1:0] row_s1;
	row_bits_t            cols_s1;
	logic                 end_s1;

	// block state
	row_bits_t          pending_q [ROWS];
	row_bits_t          stable_q  [ROWS];
	logic               pend_flag_q;
	logic [IDLE_W-1:0]  idle_q;
	logic               sleep_q;

	// result register
	logic      out_valid_q;
	row_bits_t out_row_q;
	logic      out_changed_q;
	logic      out_commit_q;
	logic      out_enter_q;
	logic      out_wake_q;
	logic      out_asleep_q;

	logic advance;
	assign advance = s1_valid && (!out_valid_q || results.ready);
	assign samples.ready = !s1_valid || advance;

	// step logic
	logic              row_ok;
	logic [ROW_W-1:0]  ridx;
	row_bits_t         cur_pending;
	row_bits_t         cur_stable;
	logic              bypass;
	logic              is_tick;
	logic              awake_sample;
	logic              changed;
	logic              wake;
	logic              commit;
	logic              enter;
	logic [IDLE_W-1:0] idle_mid;
	logic [IDLE_W-1:0] idle_nxt;
	logic              pend_mid;
	row_bits_t         stable_row_nxt;

	always_comb begin
		row_ok       = {{(32 - ROW_IDX_W){1'b0}}, row_s1} < 32'(ROWS);
		ridx         = row_ok ? ROW_W'(row_s1) : '0;
		cur_pending  = pending_q[ridx];
		cur_stable   = stable_q[ridx];
		bypass       = (delay_q == '0);
		is_tick      = (cmd_s1 == CMD_TICK);
		awake_sample = !is_tick && !sleep_q;
		wake         = !is_tick && sleep_q && (cols_s1 != '0);

		changed = 1'b0;
		if (awake_sample && row_ok) begin
			changed = bypass ? (cur_stable != cols_s1) : (cur_pending != cols_s1);
		end

		if (is_tick) begin
			idle_mid = (idle_q != IDLE_MAX) ? idle_q + IDLE_W'(1) : idle_q;
		end else if (wake || changed) begin
			idle_mid = '0;
		end else begin
			idle_mid = idle_q;
		end
		idle_nxt = idle_mid;

		pend_mid = pend_flag_q || (changed && !bypass);
		commit   = awake_sample && end_s1 && !bypass && pend_mid &&
			(idle_mid > {{(IDLE_W - DELAY_W){1'b0}}, delay_q});
		enter    = awake_sample && end_s1 && (idle_mid > psave_q);

		// addressed stable row as it stands after the step
		if (wake) begin
			stable_row_nxt = '0;
		end else if (awake_sample && row_ok && (bypass || commit)) begin
			stable_row_nxt = cols_s1;
		end else begin
			stable_row_nxt = cur_stable;
		end
		if (!row_ok) begin
			stable_row_nxt = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= DELAY_RESET;
			psave_q <= PSAVE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEBOUNCE_DELAY: delay_q <= cfg_wdata[DELAY_W-1:0];
				REG_POWER_SAVE:     psave_q <= cfg_wdata[IDLE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (samples.ready) begin
			s1_valid <= samples.valid;
		end
	end

	// payload of the input register
	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			cmd_s1  <= samples.command;
			row_s1  <= samples.row_index;
			cols_s1 <= samples.column_bits & COL_MASK;
			end_s1  <= samples.scan_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ROWS; r++) begin
				pending_q[r] <= '0;
				stable_q[r]  <= '0;
			end
			pend_flag_q <= 1'b0;
			idle_q      <= '0;
			sleep_q     <= 1'b0;
		end else if (advance) begin
			idle_q <= idle_nxt;
			if (wake) begin
				for (int r = 0; r < ROWS; r++) begin
					pending_q[r] <= '0;
					stable_q[r]  <= '0;
				end
				sleep_q <= 1'b0;
			end else if (awake_sample) begin
				for (int r = 0; r < ROWS; r++) begin
					if (row_ok && (ridx == ROW_W'(r))) begin
						pending_q[r] <= cols_s1;
						if (bypass || commit) begin
							stable_q[r] <= cols_s1;
						end
					end else if (commit) begin
						stable_q[r] <= pending_q[r];
					end
				end
				pend_flag_q <= commit ? 1'b0 : pend_mid;
				if (enter) begin
					sleep_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_row_q     <= stable_row_nxt;
			out_changed_q <= changed;
			out_commit_q  <= commit;
			out_enter_q   <= enter;
			out_wake_q    <= wake;
			out_asleep_q  <= (sleep_q && !wake) || enter;
		end
	end

	assign results.valid         = out_valid_q;
	assign results.stable_row    = out_row_q;
	assign results.row_changed   = out_changed_q;
	assign results.committed     = out_commit_q;
	assign results.entered_sleep = out_enter_q;
	assign results.woke_up       = out_wake_q;
	assign results.asleep        = out_asleep_q;

`ifndef SYNTH
	// going to sleep always shows up in the result it belongs to
	a_sleep_reported: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sleep_q) |-> out_valid_q && out_enter_q && out_asleep_q)
		else $error("sleep entered without matching result");

	a_wake_reported: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(sleep_q) |-> out_valid_q && out_wake_q && !out_asleep_q)
		else $error("wake-up without matching result");

	// a commit leaves nothing pending
	a_commit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && commit |=> !pend_flag_q)
		else $error("pending flag left set after commit");
`endif
endmodule
`default_nettype wire
